// ----- rtl/core/lshp_pkg.sv -----
// lshp_pkg: shared types, codes and helpers for the literals section header parser
`default_nettype none

package lshp_pkg;

  // block type codes from the two low bits of the first header byte
  localparam logic [1:0] BT_RAW  = 2'd0;
  localparam logic [1:0] BT_RLE  = 2'd1;
  localparam logic [1:0] BT_COMP = 2'd2;
  localparam logic [1:0] BT_TREELESS = 2'd3;

  // size format codes for compressed blocks
  localparam logic [1:0] SF_ONE_STREAM = 2'd0;
  localparam logic [1:0] SF_FOUR_10    = 2'd1;
  localparam logic [1:0] SF_FOUR_14    = 2'd2;
  localparam logic [1:0] SF_FOUR_18    = 2'd3;

  // result outcome codes
  typedef enum logic [2:0] {
    OUT_TRUNC    = 3'd0,
    OUT_RAW      = 3'd1,
    OUT_RLE      = 3'd2,
    OUT_COMP     = 3'd3,
    OUT_TREELESS = 3'd4
  } outcome_t;

  // one complete header handed from front to back
  typedef struct packed {
    logic [7:0]  fb;
    logic [31:0] later;
    logic [20:0] avail;
  } hdr_rec_t;

  // queue occupancy seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // header length in bytes implied by the first byte
  function automatic logic [2:0] hdr_len(input logic [7:0] fb);
    logic [2:0] len;
    len = 3'd1;
    if (fb[1]) begin
      case (fb[3:2])
        SF_ONE_STREAM: len = 3'd3;
        SF_FOUR_10:    len = 3'd3;
        SF_FOUR_14:    len = 3'd4;
        SF_FOUR_18:    len = 3'd5;
        default:       len = 3'd3;
      endcase
    end else if (!fb[2]) begin
      len = 3'd1;
    end else if (!fb[3]) begin
      len = 3'd2;
    end else begin
      len = 3'd3;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lshp_front.sv -----
// lshp_front: byte intake, header assembly and hand-off of complete headers
`default_nettype none

module lshp_front
  import lshp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first,
  input  wire logic [20:0] section_avail,
  input  wire q_status_t   q_stat,
  output logic             push,
  output hdr_rec_t         push_rec
);

  logic        accept;
  logic [2:0]  byte_position;
  logic [2:0]  byte_position_next;
  logic [7:0]  first_byte;
  logic [31:0] later_bytes;
  logic [31:0] later_bytes_next;
  logic [20:0] bytes_available;
  logic        header_done;
  logic        header_done_next;
  logic [2:0]  new_len;
  logic [2:0] cur_len;

  // hold the producer off while the queue has no room
  assign byte_stall = q_stat.full;
  assign accept     = byte_valid && !byte_stall;

  assign new_len = hdr_len(data_byte);
  assign cur_len = hdr_len(first_byte);

  // merge a later header byte at its slot
  always_comb begin
    later_bytes_next = later_bytes;
    case (byte_position)
      3'd1:    later_bytes_next[7:0]   = data_byte;
      3'd2:    later_bytes_next[15:8]  = data_byte;
      3'd3:    later_bytes_next[23:16] = data_byte;
      3'd4:    later_bytes_next[31:24] = data_byte;
      default: later_bytes_next = later_bytes;
    endcase
  end

  // decide whether this beat completes a header
  always_comb begin
    byte_position_next = byte_position + 3'd1;
    header_done_next   = header_done;
    push               = 1'b0;
    push_rec.fb        = first_byte;
    push_rec.later     = later_bytes_next;
    push_rec.avail     = bytes_available;
    if (accept) begin
      if (first) begin
        byte_position_next = 3'd1;
        push_rec.fb        = data_byte;
        push_rec.later     = '0;
        push_rec.avail     = section_avail;
        if ((section_avail < {18'd0, new_len}) || (new_len == 3'd1)) begin
          push             = 1'b1;
          header_done_next = 1'b1;
        end else begin
          header_done_next = 1'b0;
        end
      end else if (!header_done) begin
        if (byte_position_next >= cur_len) begin
          push             = 1'b1;
          header_done_next = 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      header_done   <= 1'b1;
    end else if (accept && (first || !header_done)) begin
      byte_position <= byte_position_next;
      header_done   <= header_done_next;
    end
  end

  // header byte registers
  always_ff @(posedge clk) begin
    if (accept && first) begin
      first_byte      <= data_byte;
      later_bytes     <= '0;
      bytes_available <= section_avail;
    end else if (accept && !header_done) begin
      later_bytes <= later_bytes_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lshp_queue.sv -----
// lshp_queue: two-entry queue of complete headers between front and back
`default_nettype none

module lshp_queue
  import lshp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire hdr_rec_t push_rec,
  input  wire logic     pop,
  output hdr_rec_t      head,
  output q_status_t     q_stat
);

  hdr_rec_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head         = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lshp_back.sv -----
// lshp_back: header decode, bounds check and registered result beat
`default_nettype none

module lshp_back
  import lshp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire hdr_rec_t     head,
  input  wire q_status_t    q_stat,
  output logic              pop,
  output logic              res_valid,
  input  wire logic         res_stall,
  output logic [2:0]        outcome,
  output logic              single_stream,
  output logic [19:0]       regenerated_size,
  output logic [2:0]        header_length,
  output logic [19:0]       payload_length
);

  logic [7:0]  fb;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic [7:0]  b4;
  logic [2:0]  hlen;
  logic [19:0] regen;
  logic [19:0] payload;
  outcome_t    kind;
  logic        single;
  logic [20:0] remain;
  logic        trunc;

  assign fb = head.fb;
  assign b1 = head.later[7:0];
  assign b2 = head.later[15:8];
  assign b3 = head.later[23:16];
  assign b4 = head.later[31:24];
  assign hlen = hdr_len(fb);

  // field extraction per block type and size format
  always_comb begin
    regen   = '0;
    payload = '0;
    single  = 1'b0;
    kind    = OUT_RAW;
    if (fb[1]) begin
      kind = (fb[1:0] == BT_TREELESS) ? OUT_TREELESS : OUT_COMP;
      case (fb[3:2])
        SF_ONE_STREAM, SF_FOUR_10: begin
          single  = (fb[3:2] == SF_ONE_STREAM);
          regen   = {10'd0, b1[5:0], fb[7:4]};
          payload = {10'd0, b2, b1[7:6]};
        end
        SF_FOUR_14: begin
          regen   = {6'd0, b2[1:0], b1, fb[7:4]};
          payload = {6'd0, b3, b2[7:2]};
        end
        SF_FOUR_18: begin
          regen   = {2'd0, b2[5:0], b1, fb[7:4]};
          payload = {2'd0, b4, b3, b2[7:6]};
        end
        default: begin
          regen   = '0;
          payload = '0;
        end
      endcase
    end else begin
      if (!fb[2]) begin
        regen = {15'd0, fb[7:3]};
      end else if (!fb[3]) begin
        regen = {8'd0, b1, fb[7:4]};
      end else begin
        regen = {b2, b1, fb[7:4]};
      end
      if (fb[1:0] == BT_RLE) begin
        kind    = OUT_RLE;
        payload = 20'd1;
      end else begin
        kind    = OUT_RAW;
        payload = regen;
      end
    end
  end

  // header and payload must fit in the section
  assign remain = head.avail - {18'd0, hlen};
  assign trunc  = (head.avail < {18'd0, hlen}) || (remain < {1'b0, payload});

  // load a new result when the output register is free or draining
  assign pop = !q_stat.empty && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (trunc) begin
        outcome          <= OUT_TRUNC;
        single_stream    <= 1'b0;
        regenerated_size <= '0;
        header_length    <= '0;
        payload_length   <= '0;
      end else begin
        outcome          <= kind;
        single_stream    <= single;
        regenerated_size <= regen;
        header_length    <= hlen;
        payload_length   <= payload;
      end
    end
  end

`ifndef SYNTH
  // truncated results carry no sizes
  a_trunc_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (outcome == OUT_TRUNC)) |->
      (!single_stream && (regenerated_size == 20'd0) &&
       (header_length == 3'd0) && (payload_length == 20'd0)))
    else $error("truncated result with nonzero fields");

  // a decoded header is one to five bytes long
  a_hlen_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (outcome != OUT_TRUNC)) |->
      ((header_length >= 3'd1) && (header_length <= 3'd5)))
    else $error("header length out of range");

  // run-length payload is a single byte
  a_rle_payload: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (outcome == OUT_RLE)) |-> (payload_length == 20'd1))
    else $error("run-length payload not one byte");

  // single stream only for compressed literals
  a_single_comp: assert property (@(posedge clk) disable iff (rst)
    (res_valid && single_stream) |->
      ((outcome == OUT_COMP) || (outcome == OUT_TREELESS)))
    else $error("single stream flag on uncompressed literals");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/literals_section_header_parser.sv -----
// literals_section_header_parser: top level of the literals section header parser
//
// Input channel: one header byte per beat (data_byte, first, section_avail),
// handshake byte_valid / byte_stall. first marks the opening byte of a header;
// section_avail is sampled with that byte only.
// Output channel: one result beat per header (outcome, single_stream,
// regenerated_size, header_length, payload_length), handshake res_valid /
// res_stall.
// Throughput: one byte per cycle while byte_stall is low. The front assembles
// header bytes and hands each complete header to a two-entry queue; the back
// decodes the queue head and checks the sizes into the output register.
// Path: with the output register free, the final header byte is written into
// the queue, and the queue head is then decoded and loaded into the output
// register, which raises res_valid.
// Stall: a stalled result holds in the output register while the front keeps
// taking bytes until the queue fills; byte_stall rises only when it is full.
// Reset: synchronous; clears queue and output valid and leaves the parser
// waiting for a first byte. Bytes without first while idle are dropped.
`default_nettype none

module literals_section_header_parser
  import lshp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first,
  input  wire logic [20:0] section_avail,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [2:0]       outcome,
  output logic             single_stream,
  output logic [19:0]      regenerated_size,
  output logic [2:0]       header_length,
  output logic [19:0]      payload_length
);

  logic      push;
  logic      pop;
  hdr_rec_t  push_rec;
  hdr_rec_t  head;
  q_status_t q_stat;

  // byte intake and header assembly
  lshp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .first         (first),
    .section_avail (section_avail),
    .q_stat        (q_stat),
    .push          (push),
    .push_rec      (push_rec)
  );

  // queue of complete headers
  lshp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // decode and result register
  lshp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .outcome          (outcome),
    .single_stream    (single_stream),
    .regenerated_size (regenerated_size),
    .header_length    (header_length),
    .payload_length   (payload_length)
  );

endmodule

`default_nettype wire
